>>> rtl/bld_pkg.sv
// Shared constants, codes and types for the block linear detrend core.
`default_nettype none
package bld_pkg;

  localparam int MAX_LEN     = 4096;
  localparam int SAMPLE_BITS = 24;
  localparam int ADDR_W      = $clog2(MAX_LEN);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int SUM_W       = 37;
  localparam int WSUM_W      = 48;
  localparam int RES_W       = 26;
  localparam int ICPT_W      = 41;
  localparam int SLOPE_W     = 49;
  localparam int FRAC_I      = 16;
  localparam int FRAC_S      = 24;
  localparam int NUM_W       = 54;
  localparam int DEN_W       = 37;
  localparam int DIVD_W      = NUM_W + FRAC_S + 1;
  localparam int DCNT_W      = $clog2(DIVD_W);
  localparam int FIX_W       = DIVD_W + 2;
  localparam int TR_W        = 64;
  localparam int RD_W        = TR_W + 2;
  localparam int RES_SH      = 24;
  localparam int ICPT_SH     = RES_SH - FRAC_I;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic MODE_LOAD      = 1'b0;
  localparam logic MODE_EMIT      = 1'b1;
  localparam logic DETREND_MEAN   = 1'b0;
  localparam logic DETREND_LINEAR = 1'b1;
  localparam logic CFG_IDX_MODE   = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EMIT,
    ST_FIT0,
    ST_FIT1,
    ST_FIT2,
    ST_DIV_I,
    ST_POST_I,
    ST_DIV_S,
    ST_POST_S
  } bld_state_e;

endpackage
`default_nettype wire

>>> rtl/bld_if.sv
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface bld_in_if;
  import bld_pkg::*;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;
  modport source (output valid, output mode, output sample, output last, input ready);
  modport sink (input valid, input mode, input sample, input last, output ready);
endinterface

interface bld_out_if;
  import bld_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [RES_W-1:0]   residual;
  logic signed [ICPT_W-1:0]  intercept_q16;
  logic signed [SLOPE_W-1:0] slope_q24;
  logic                      last_residual;
  modport source (output valid, output residual, output intercept_q16, output slope_q24,
                  output last_residual, input ready);
  modport sink (input valid, input residual, input intercept_q16, input slope_q24,
                input last_residual, output ready);
endinterface
`default_nettype wire

>>> rtl/block_linear_detrend_core.sv
// Block linear detrend core: sample store, running sums, fit sequencer and residual output.
// A load that ends the block starts a fit: setup states FIT0, FIT1 and FIT2, then one
// bit-serial division (mean mode, or a one-sample block in linear mode) or two (linear
// mode), each followed by a rounding state; no item is taken during the fit.
// An emit request does one sample store read, then the residual is registered.
// Reset (rst_ni low, asynchronous) empties the block and sets linear mode; the store is not cleared.
`default_nettype none
module block_linear_detrend_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bld_in_if.sink                       in_i,
  bld_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bld_pkg::PADDR_W-1:0]  paddr,
  input  logic [bld_pkg::PDATA_W-1:0]  pwdata,
  output logic [bld_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import bld_pkg::*;

  bld_state_e state_q, state_d;

  logic                      mode_q;
  logic [CNT_W-1:0]          cnt_q, ridx_q;
  logic signed [SUM_W-1:0]   ssum_q;
  logic signed [WSUM_W-1:0]  wsum_q;
  logic                      fit_rdy_q;
  logic signed [ICPT_W-1:0]  icpt_q;
  logic signed [SLOPE_W-1:0] slope_q;
  logic signed [TR_W-1:0]    trend_q;

  logic signed [NUM_W-1:0]   p1_q, num_i_q, num_s_q;
  logic [2*CNT_W-1:0]        nn_q;
  logic [DEN_W-1:0]          den_i_q, den_s_q;
  logic                      lin_q;

  logic [DIVD_W-1:0]         divd_q;
  logic [DEN_W-1:0]          rem_q;
  logic [DCNT_W-1:0]         dcnt_q;
  logic                      dneg_q;

  logic                      out_vld_q, last_res_q;
  logic signed [RES_W-1:0]   res_q;
  logic signed [ICPT_W-1:0]  out_icpt_q;
  logic signed [SLOPE_W-1:0] out_slope_q;

  logic [SAMPLE_BITS-1:0]        mem [MAX_LEN];
  logic signed [SAMPLE_BITS-1:0] rd_q;

  // handshake and load path
  logic                           in_acc, is_load, is_emit, room, mem_we;
  logic [CNT_W-1:0]               base_cnt;
  logic signed [SUM_W-1:0]        base_s;
  logic signed [WSUM_W-1:0]       base_w;
  logic signed [CNT_W+SAMPLE_BITS:0] prod_w;

  // fit path
  logic [CNT_W:0]                 mul_n;
  logic signed [CNT_W+SUM_W:0]    mul_a;
  logic [2*CNT_W-1:0]             nn_mul;
  logic [3*CNT_W-1:0]             dsm;
  logic signed [NUM_W-1:0]        w_ext, s_ext, w6, w12, p6, start_num;
  logic [NUM_W-1:0]               mag;
  logic [DIVD_W-1:0]              divd_start;
  logic                           div_step, div_load, div_done;

  // divider step and rounding
  logic [DEN_W-1:0]               den_sel;
  logic [DEN_W:0]                 trial, diff;
  logic                           ge;
  logic signed [FIX_W-1:0]        q_ext, tq, tp1, rv;
  logic                           rnz, icpt_ok, slope_ok;
  logic signed [ICPT_W-1:0]       icpt_fix;
  logic signed [SLOPE_W-1:0]      slope_fix;

  // residual
  logic signed [RD_W-1:0]         xs, dd, rfull;
  logic                           res_ok;
  logic signed [RES_W-1:0]        res_sat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_MODE) ? {{(PDATA_W-1){1'b0}}, mode_q} : '0;

  assign in_acc  = in_i.valid && in_i.ready;
  assign is_load = in_acc && (in_i.mode == MODE_LOAD);
  assign is_emit = in_acc && (in_i.mode == MODE_EMIT) && fit_rdy_q && (ridx_q < cnt_q);

  assign base_cnt = fit_rdy_q ? '0 : cnt_q;
  assign base_s   = fit_rdy_q ? '0 : ssum_q;
  assign base_w   = fit_rdy_q ? '0 : wsum_q;
  assign room     = base_cnt < CNT_W'(MAX_LEN);
  assign mem_we   = is_load && room;
  assign prod_w   = $signed({1'b0, base_cnt}) * in_i.sample;

  assign mul_n  = (state_q == ST_FIT0) ? ({cnt_q, 1'b0} - (CNT_W+1)'(1))
                                       : ({1'b0, cnt_q} - (CNT_W+1)'(1));
  assign mul_a  = $signed({1'b0, mul_n}) * ssum_q;
  assign nn_mul = cnt_q * cnt_q;
  assign dsm    = cnt_q * nn_q;

  assign w_ext = NUM_W'(wsum_q);
  assign s_ext = NUM_W'(ssum_q);
  assign w6    = (w_ext <<< 2) + (w_ext <<< 1);
  assign w12   = (w_ext <<< 3) + (w_ext <<< 2);
  assign p6    = (p1_q <<< 2) + (p1_q <<< 1);

  assign start_num  = (state_q == ST_FIT2) ? num_i_q : num_s_q;
  assign mag        = start_num[NUM_W-1] ? NUM_W'(-start_num) : NUM_W'(start_num);
  assign divd_start = (state_q == ST_FIT2) ? (DIVD_W'(mag) << (FRAC_I + 1))
                                           : (DIVD_W'(mag) << (FRAC_S + 1));

  assign den_sel = (state_q == ST_DIV_I) ? den_i_q : den_s_q;
  assign trial   = {rem_q, divd_q[DIVD_W-1]};
  assign ge      = trial >= {1'b0, den_sel};
  assign diff    = trial - {1'b0, den_sel};
  assign div_done = dcnt_q == DCNT_W'(DIVD_W - 1);

  assign rnz   = |rem_q;
  assign q_ext = $signed({2'b00, divd_q});
  assign tq    = dneg_q ? -(q_ext + FIX_W'(rnz)) : q_ext;
  assign tp1   = tq + FIX_W'(1);
  assign rv    = tp1 >>> 1;

  assign icpt_ok  = (&rv[FIX_W-1:ICPT_W-1]) || !(|rv[FIX_W-1:ICPT_W-1]);
  assign icpt_fix = icpt_ok ? rv[ICPT_W-1:0]
                  : (rv[FIX_W-1] ? {1'b1, {(ICPT_W-1){1'b0}}} : {1'b0, {(ICPT_W-1){1'b1}}});
  assign slope_ok  = (&rv[FIX_W-1:SLOPE_W-1]) || !(|rv[FIX_W-1:SLOPE_W-1]);
  assign slope_fix = slope_ok ? rv[SLOPE_W-1:0]
                   : (rv[FIX_W-1] ? {1'b1, {(SLOPE_W-1){1'b0}}} : {1'b0, {(SLOPE_W-1){1'b1}}});

  assign xs      = RD_W'(rd_q);
  assign dd      = (xs <<< RES_SH) - RD_W'(trend_q) + (RD_W'(1) <<< (RES_SH - 1));
  assign rfull   = dd >>> RES_SH;
  assign res_ok  = (&rfull[RD_W-1:RES_W-1]) || !(|rfull[RD_W-1:RES_W-1]);
  assign res_sat = res_ok ? rfull[RES_W-1:0]
                 : (rfull[RD_W-1] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (is_load && in_i.last) state_d = ST_FIT0;
        else if (is_emit)         state_d = ST_EMIT;
      end
      ST_EMIT:   state_d = ST_IDLE;
      ST_FIT0:   state_d = ST_FIT1;
      ST_FIT1:   state_d = ST_FIT2;
      ST_FIT2:   state_d = ST_DIV_I;
      ST_DIV_I:  if (div_done) state_d = ST_POST_I;
      ST_POST_I: state_d = lin_q ? ST_DIV_S : ST_IDLE;
      ST_DIV_S:  if (div_done) state_d = ST_POST_S;
      ST_POST_S: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    div_step   = 1'b0;
    div_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_i.ready = (in_i.mode == MODE_LOAD) || !out_vld_q;
      ST_FIT2:   div_load = 1'b1;
      ST_DIV_I:  div_step = 1'b1;
      ST_POST_I: div_load = lin_q;
      ST_DIV_S:  div_step = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[base_cnt[ADDR_W-1:0]] <= in_i.sample;
    end
    rd_q <= mem[ridx_q[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mode_q    <= DETREND_LINEAR;
      cnt_q     <= '0;
      ridx_q    <= '0;
      ssum_q    <= '0;
      wsum_q    <= '0;
      fit_rdy_q <= 1'b0;
      icpt_q    <= '0;
      slope_q   <= '0;
      dcnt_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_MODE)) begin
        mode_q <= pwdata[0];
      end
      if (out_vld_q && out_o.ready) out_vld_q <= 1'b0;
      if (is_load) begin
        fit_rdy_q <= 1'b0;
        if (room) begin
          cnt_q  <= base_cnt + CNT_W'(1);
          ssum_q <= base_s + SUM_W'(in_i.sample);
          wsum_q <= base_w + WSUM_W'(prod_w);
        end else begin
          cnt_q  <= base_cnt;
          ssum_q <= base_s;
          wsum_q <= base_w;
        end
      end
      if (div_load) begin
        divd_q <= divd_start;
        rem_q  <= '0;
        dneg_q <= start_num[NUM_W-1];
        dcnt_q <= '0;
      end else if (div_step) begin
        divd_q <= {divd_q[DIVD_W-2:0], ge};
        rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end
      unique case (state_q)
        ST_EMIT: begin
          out_vld_q   <= 1'b1;
          res_q       <= res_sat;
          out_icpt_q  <= icpt_q;
          out_slope_q <= slope_q;
          last_res_q  <= ridx_q == (cnt_q - CNT_W'(1));
          ridx_q      <= ridx_q + CNT_W'(1);
          trend_q     <= trend_q + TR_W'(slope_q);
        end
        ST_FIT0: begin
          p1_q  <= NUM_W'(mul_a);
          nn_q  <= nn_mul;
          lin_q <= (mode_q == DETREND_LINEAR) && (cnt_q != CNT_W'(1));
        end
        ST_FIT1: begin
          num_i_q <= lin_q ? (p1_q <<< 1) - w6 : s_ext;
          den_i_q <= lin_q ? DEN_W'(nn_q) + DEN_W'(cnt_q) : DEN_W'(cnt_q);
          p1_q    <= NUM_W'(mul_a);
          nn_q    <= nn_q - (2*CNT_W)'(1);
        end
        ST_FIT2: begin
          num_s_q <= w12 - p6;
          den_s_q <= DEN_W'(dsm);
        end
        ST_POST_I: begin
          icpt_q  <= icpt_fix;
          trend_q <= TR_W'(icpt_fix) <<< ICPT_SH;
          if (!lin_q) begin
            slope_q   <= '0;
            fit_rdy_q <= 1'b1;
            ridx_q    <= '0;
          end
        end
        ST_POST_S: begin
          slope_q   <= slope_fix;
          fit_rdy_q <= 1'b1;
          ridx_q    <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.residual      = res_q;
  assign out_o.intercept_q16 = out_icpt_q;
  assign out_o.slope_q24     = out_slope_q;
  assign out_o.last_residual = last_res_q;

endmodule
`default_nettype wire

>>> rtl/bld_checker.sv
// Port-level assertions for the block linear detrend core and their bind.
`default_nettype none
module bld_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_mode,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [bld_pkg::RES_W-1:0] out_residual
);
  import bld_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_residual))
    else $error("residual changed while stalled");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_mode == MODE_LOAD) && !out_valid |=> !out_valid)
    else $error("load item produced a result");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_mode == MODE_EMIT) |-> !out_valid || out_ready)
    else $error("emit item taken while result slot busy");

endmodule

bind block_linear_detrend_core bld_checker u_bld_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .in_mode      (in_i.mode),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .out_residual (out_o.residual)
);
`default_nettype wire
